// ===== hdl/tqb_pkg.sv =====
// ----------------------------------------------------------------------------
// tqb_pkg - shared types and constants for the three-queue balancer
// Queue geometry, field widths, status codes and the rebalance pair order.
// ----------------------------------------------------------------------------
package tqb_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TICKET_BITS = 16;
  localparam int NUM_QUEUES  = 3;
  localparam int NUM_PAIRS   = 6;

  // per-queue fill count, able to hold QUEUE_DEPTH itself
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  // width of the config fields and of the count fields on the result port
  localparam int CFG_W     = 5;
  localparam int CNT_OUT_W = 5;
  // compare width: wide enough for a count or a config value plus one carry
  localparam int CMP_W = ((COUNT_W > CFG_W) ? COUNT_W : CFG_W) + 1;

  localparam int QSEL_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMBALANCE_LIMIT = 2'd1;

  localparam logic [CFG_W-1:0] QUEUE_LIMIT_RST     = 5'd10;
  localparam logic [CFG_W-1:0] IMBALANCE_LIMIT_RST = 5'd3;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_BAD_SEL = 2'd3
  } status_t;

  // checked in this order, first hit wins
  localparam logic [QSEL_W-1:0] PAIR_SRC [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [QSEL_W-1:0] PAIR_DST [NUM_PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

  // first phase of a step: the command's own push or pop
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic [TICKET_BITS-1:0] data;
  } qctl_a_t;

  // second phase: the rebalance move
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic [TICKET_BITS-1:0] data;
  } qctl_b_t;

endpackage

// ===== hdl/tqb_queue.sv =====
// ----------------------------------------------------------------------------
// tqb_queue - one bounded shifting ticket FIFO
// Head sits at entry 0. One step applies a command push/pop, then a
// rebalance push/pop, and registers the result.
// ----------------------------------------------------------------------------
module tqb_queue
  import tqb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  qctl_a_t                ctl_a,
  input  qctl_b_t                ctl_b,
  output logic [COUNT_W-1:0]     count,
  output logic [COUNT_W-1:0]     count_mid,
  output logic [TICKET_BITS-1:0] head,
  output logic [TICKET_BITS-1:0] head_mid
);

  logic [TICKET_BITS-1:0] entry      [QUEUE_DEPTH];
  logic [TICKET_BITS-1:0] entry_mid  [QUEUE_DEPTH];
  logic [TICKET_BITS-1:0] entry_next [QUEUE_DEPTH];
  logic [COUNT_W-1:0]     count_next;

  // after the command phase
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ctl_a.pop && (i < QUEUE_DEPTH - 1)) begin
        entry_mid[i] = entry[i + 1];
      end else begin
        entry_mid[i] = entry[i];
      end
      if (ctl_a.push && (count == COUNT_W'(i))) begin
        entry_mid[i] = ctl_a.data;
      end
    end
  end

  assign count_mid = count + COUNT_W'(ctl_a.push) - COUNT_W'(ctl_a.pop);
  assign head      = entry[0];
  assign head_mid  = entry_mid[0];

  // after the rebalance phase
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ctl_b.pop && (i < QUEUE_DEPTH - 1)) begin
        entry_next[i] = entry_mid[i + 1];
      end else begin
        entry_next[i] = entry_mid[i];
      end
      if (ctl_b.push && (count_mid == COUNT_W'(i))) begin
        entry_next[i] = ctl_b.data;
      end
    end
  end

  assign count_next = count_mid + COUNT_W'(ctl_b.push) - COUNT_W'(ctl_b.pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // ticket payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entry[i] <= entry_next[i];
    end
  end

endmodule

// ===== hdl/three_queue_balancer_top.sv =====
// ----------------------------------------------------------------------------
// three_queue_balancer_top - three ticket queues with one-move rebalancing
// Enqueue into queue 0 or serve the head of a chosen queue, then move at
// most one ticket between queues whose fill counts drift too far apart.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  --------  ----------------------  ------------------------------------------
//  command   start, busy             cmd, queue_sel, ticket
//  result    done (one-cycle strobe) status, served_valid, served_ticket, moved,
//                                    move_from, move_to, count_a/b/c
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
//  One command transaction per cycle; busy never rises.
//  The result strobes done in the cycle after its command was taken.
//  Whole step (command push/pop plus rebalance move) is one combinational
//  pass from the queue registers to the result registers.
//  Synchronous reset empties all queues and loads the register defaults
//  (queue_limit 10, imbalance_limit 3). The result side has no backpressure.
//
module three_queue_balancer_top
  import tqb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // command
  input  logic                   start,
  output logic                   busy,
  input  logic                   cmd,
  input  logic [QSEL_W-1:0]      queue_sel,
  input  logic [TICKET_BITS-1:0] ticket,
  // result
  output logic                   done,
  output logic [1:0]             status,
  output logic                   served_valid,
  output logic [TICKET_BITS-1:0] served_ticket,
  output logic                   moved,
  output logic [QSEL_W-1:0]      move_from,
  output logic [QSEL_W-1:0]      move_to,
  output logic [CNT_OUT_W-1:0]   count_a,
  output logic [CNT_OUT_W-1:0]   count_b,
  output logic [CNT_OUT_W-1:0]   count_c,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  // config registers
  logic [CFG_W-1:0] queue_limit;
  logic [CFG_W-1:0] imbalance_limit;

  // queue interface
  qctl_a_t                ctl_a     [NUM_QUEUES];
  qctl_b_t                ctl_b     [NUM_QUEUES];
  logic [COUNT_W-1:0]     q_count   [NUM_QUEUES];
  logic [COUNT_W-1:0]     q_cnt_mid [NUM_QUEUES];
  logic [TICKET_BITS-1:0] q_head    [NUM_QUEUES];
  logic [TICKET_BITS-1:0] q_hd_mid  [NUM_QUEUES];

  // step decode
  logic [CMP_W-1:0]       eff_limit;
  logic                   q0_full;
  logic                   sel_bad;
  logic                   sel_empty;
  logic                   do_pop;
  logic                   pair_hit  [NUM_PAIRS];
  logic                   move_hit;
  logic [QSEL_W-1:0]      mv_src;
  logic [QSEL_W-1:0]      mv_dst;
  logic                   dst_full;

  // result register next values
  status_t                status_next;
  logic [TICKET_BITS-1:0] served_ticket_next;

  // result registers
  status_t                status_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit     <= QUEUE_LIMIT_RST;
      imbalance_limit <= IMBALANCE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUEUE_LIMIT:     queue_limit     <= cfg_data;
        CFG_IMBALANCE_LIMIT: imbalance_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective capacity: queue_limit saturated at the physical depth
  always_comb begin
    if (CMP_W'(queue_limit) > CMP_W'(QUEUE_DEPTH)) begin
      eff_limit = CMP_W'(QUEUE_DEPTH);
    end else begin
      eff_limit = CMP_W'(queue_limit);
    end
  end

  // command phase
  assign q0_full   = CMP_W'(q_count[0]) >= eff_limit;
  assign sel_bad   = queue_sel >= QSEL_W'(NUM_QUEUES);
  assign sel_empty = !sel_bad && (q_count[queue_sel] == '0);
  assign do_pop    = start && (cmd == CMD_ADVANCE) && !sel_bad && !sel_empty;

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      ctl_a[q].push = start && (cmd == CMD_ENQUEUE) && (q == 0) && !q0_full;
      ctl_a[q].pop  = do_pop && (queue_sel == QSEL_W'(q));
      ctl_a[q].data = ticket;
    end
  end

  // rebalance phase, on counts left by the command phase
  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      pair_hit[p] = CMP_W'(q_cnt_mid[PAIR_SRC[p]]) >
                    CMP_W'(q_cnt_mid[PAIR_DST[p]]) + CMP_W'(imbalance_limit);
    end
  end

  // first pair in the fixed order wins
  always_comb begin
    move_hit = 1'b0;
    mv_src   = '0;
    mv_dst   = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      if (!move_hit && pair_hit[p]) begin
        move_hit = 1'b1;
        mv_src   = PAIR_SRC[p];
        mv_dst   = PAIR_DST[p];
      end
    end
  end

  // a full destination drops the moved ticket; the source still loses it
  assign dst_full = CMP_W'(q_cnt_mid[mv_dst]) >= eff_limit;

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      ctl_b[q].pop  = start && move_hit && (mv_src == QSEL_W'(q));
      ctl_b[q].push = start && move_hit && !dst_full && (mv_dst == QSEL_W'(q));
      ctl_b[q].data = q_hd_mid[mv_src];
    end
  end

  for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
    tqb_queue u_queue (
      .clk       (clk),
      .rst       (rst),
      .ctl_a     (ctl_a[q]),
      .ctl_b     (ctl_b[q]),
      .count     (q_count[q]),
      .count_mid (q_cnt_mid[q]),
      .head      (q_head[q]),
      .head_mid  (q_hd_mid[q])
    );
  end

  // result of this transaction
  always_comb begin
    served_ticket_next = '0;
    if (cmd == CMD_ENQUEUE) begin
      status_next = q0_full ? STATUS_FULL : STATUS_OK;
    end else if (sel_bad) begin
      status_next = STATUS_BAD_SEL;
    end else if (sel_empty) begin
      status_next = STATUS_EMPTY;
    end else begin
      status_next        = STATUS_OK;
      served_ticket_next = q_head[queue_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start && !busy;
    end
  end

  // payload of the result, no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      status_r      <= status_next;
      served_valid  <= do_pop;
      served_ticket <= served_ticket_next;
      moved         <= move_hit;
      move_from     <= move_hit ? mv_src : '0;
      move_to       <= move_hit ? mv_dst : '0;
    end
  end

  assign status = status_r;

  // queue counts already hold the post-step values while done is high
  assign count_a = CNT_OUT_W'(q_count[0]);
  assign count_b = CNT_OUT_W'(q_count[1]);
  assign count_c = CNT_OUT_W'(q_count[2]);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the three-queue ticket balancer
// Directed table (reset state, field extremes, every status code, full and
// dropped moves) followed by random phases under several register settings
// and sender idle rates. Every result is compared against a cycle-free
// predictor of the queues and the rebalance pass.
// ----------------------------------------------------------------------------
module testbench;
  import tqb_pkg::*;

  // config index the block does not decode; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 200;

  // --------------------------------------------------------------------------
  // clock, reset and DUT signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   start = 1'b0;
  cmd_t                   cmd = CMD_ENQUEUE;
  logic [QSEL_W-1:0]      queue_sel = '0;
  logic [TICKET_BITS-1:0] ticket = '0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  logic                   busy;
  logic                   done;
  logic [1:0]             status;
  logic                   served_valid;
  logic [TICKET_BITS-1:0] served_ticket;
  logic                   moved;
  logic [QSEL_W-1:0]      move_from;
  logic [QSEL_W-1:0]      move_to;
  logic [CNT_OUT_W-1:0]   count_a;
  logic [CNT_OUT_W-1:0]   count_b;
  logic [CNT_OUT_W-1:0]   count_c;
  logic                   cfg_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_queue_balancer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .queue_sel     (queue_sel),
    .ticket        (ticket),
    .done          (done),
    .status        (status),
    .served_valid  (served_valid),
    .served_ticket (served_ticket),
    .moved         (moved),
    .move_from     (move_from),
    .move_to       (move_to),
    .count_a       (count_a),
    .count_b       (count_b),
    .count_c       (count_c),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // result and stimulus row types
  // --------------------------------------------------------------------------
  typedef struct {
    status_t                status;
    logic                   served_valid;
    logic [TICKET_BITS-1:0] served_ticket;
    logic                   moved;
    logic [QSEL_W-1:0]      move_from;
    logic [QSEL_W-1:0]      move_to;
    logic [CNT_OUT_W-1:0]   count_a;
    logic [CNT_OUT_W-1:0]   count_b;
    logic [CNT_OUT_W-1:0]   count_c;
  } step_result_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  // one table row: a command transaction or a register write; a command row
  // may carry a hand-written result that replaces the prediction
  typedef struct {
    row_kind_t              kind;
    cmd_t                   op;
    logic [QSEL_W-1:0]      sel;
    logic [TICKET_BITS-1:0] val;
    logic [CFG_IDX_W-1:0]   idx;
    bit                     has_golden;
    step_result_t           golden;
  } stim_row_t;

  step_result_t expected_results[$];  // oldest first, one per taken command
  stim_row_t    issued_rows[$];       // commands driven but not yet taken
  int           mismatch_count = 0;

  // --------------------------------------------------------------------------
  // predictor state: ticket rings, heads, fills and the two registers
  // --------------------------------------------------------------------------
  logic [TICKET_BITS-1:0] ticket_mem [NUM_QUEUES][QUEUE_DEPTH];
  int unsigned            q_head [NUM_QUEUES];
  int unsigned            q_fill [NUM_QUEUES];
  logic [CFG_W-1:0]       cap_reg;
  logic [CFG_W-1:0]       skew_reg;

  // tail append; a queue limit above the ring depth saturates to the depth
  function automatic bit q_push(int q, logic [TICKET_BITS-1:0] t);
    int unsigned lim;
    lim = (cap_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_reg;
    if (q_fill[q] >= lim) return 1'b0;
    ticket_mem[q][(q_head[q] + q_fill[q]) % QUEUE_DEPTH] = t;
    q_fill[q]++;
    return 1'b1;
  endfunction

  function automatic logic [TICKET_BITS-1:0] q_pop(int q);
    logic [TICKET_BITS-1:0] t;
    t = ticket_mem[q][q_head[q]];
    q_head[q] = (q_head[q] + 1) % QUEUE_DEPTH;
    q_fill[q]--;
    return t;
  endfunction

  // one step: the command's own push or pop, then a single rebalance pass
  function automatic step_result_t serve_and_balance(cmd_t op, logic [QSEL_W-1:0] sel,
                                                     logic [TICKET_BITS-1:0] tk);
    step_result_t r;
    int s;
    int d;
    r.status = STATUS_OK;
    r.served_valid = 1'b0;
    r.served_ticket = '0;
    r.moved = 1'b0;
    r.move_from = '0;
    r.move_to = '0;
    if (op == CMD_ENQUEUE) begin
      if (!q_push(0, tk)) r.status = STATUS_FULL;
    end else if (sel >= NUM_QUEUES) begin
      r.status = STATUS_BAD_SEL;
    end else if (q_fill[sel] == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.served_ticket = q_pop(sel);
      r.served_valid = 1'b1;
    end
    // first pair over the limit wins; a full destination drops the ticket
    for (int i = 0; i < NUM_PAIRS; i++) begin
      s = PAIR_SRC[i];
      d = PAIR_DST[i];
      if (q_fill[s] > q_fill[d] + skew_reg) begin
        void'(q_push(d, ticket_mem[s][q_head[s]]));
        void'(q_pop(s));
        r.moved = 1'b1;
        r.move_from = s[QSEL_W-1:0];
        r.move_to = d[QSEL_W-1:0];
        break;
      end
    end
    r.count_a = q_fill[0][CNT_OUT_W-1:0];
    r.count_b = q_fill[1][CNT_OUT_W-1:0];
    r.count_c = q_fill[2][CNT_OUT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned exp);
    if (got != exp) report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
  endtask

  // --------------------------------------------------------------------------
  // scoreboard: everything sampled at the rising edge, drives are all NBA so
  // the values seen here are the ones the DUT registers on this same edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    step_result_t want;
    step_result_t pred;
    stim_row_t    row;
    if (rst) begin
      foreach (q_head[q]) begin
        q_head[q] = 0;
        q_fill[q] = 0;
      end
      cap_reg = QUEUE_LIMIT_RST;
      skew_reg = IMBALANCE_LIMIT_RST;
    end else begin
      // result of the previous transaction comes first, then this edge's new one
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("status", status, want.status);
          check_field("served_valid", served_valid, want.served_valid);
          check_field("served_ticket", served_ticket, want.served_ticket);
          check_field("moved", moved, want.moved);
          check_field("move_from", move_from, want.move_from);
          check_field("move_to", move_to, want.move_to);
          check_field("count_a", count_a, want.count_a);
          check_field("count_b", count_b, want.count_b);
          check_field("count_c", count_c, want.count_c);
        end
      end
      if (start && !busy) begin
        pred = serve_and_balance(cmd, queue_sel, ticket);
        row = issued_rows.pop_front();
        expected_results.push_back(row.has_golden ? row.golden : pred);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUEUE_LIMIT:     cap_reg = cfg_data;
          CFG_IMBALANCE_LIMIT: skew_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // table row builders
  // --------------------------------------------------------------------------
  function automatic stim_row_t item_row(cmd_t op, logic [QSEL_W-1:0] sel,
                                         logic [TICKET_BITS-1:0] tk);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.op = op;
    r.sel = sel;
    r.val = tk;
    r.idx = '0;
    r.has_golden = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(cmd_t op, logic [QSEL_W-1:0] sel,
      logic [TICKET_BITS-1:0] tk, status_t st, logic sv, logic [TICKET_BITS-1:0] stk,
      logic mv, logic [QSEL_W-1:0] mf, logic [QSEL_W-1:0] mt,
      logic [CNT_OUT_W-1:0] ca, logic [CNT_OUT_W-1:0] cb, logic [CNT_OUT_W-1:0] cc);
    stim_row_t r;
    r = item_row(op, sel, tk);
    r.has_golden = 1'b1;
    r.golden = '{st, sv, stk, mv, mf, mt, ca, cb, cc};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t r;
    r = item_row(CMD_ENQUEUE, '0, '0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = TICKET_BITS'(data);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // hold start low for a random number of cycles
  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // present one command and wait for the edge that takes it; start stays high
  // so a back-to-back transaction needs no second assignment in this step
  task automatic send_row(stim_row_t row);
    issued_rows.push_back(row);
    start <= 1'b1;
    cmd <= row.op;
    queue_sel <= row.sel;
    ticket <= row.val[TICKET_BITS-1:0];
    do @(posedge clk); while (busy);
  endtask

  // registers change only with the block idle: drain, settle, then write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t directed[$];
    int        cap_plan  [NUM_PHASES] = '{1, 16, 31, 0, 10, 2, -1, 16, -1};
    int        skew_plan [NUM_PHASES] = '{0, 16, 3, 31, 1, 0, -1, 2, -1};
    int        enq_plan  [NUM_PHASES] = '{60, 80, 70, 40, 60, 55, 60, 75, 50};
    int        idle_pct;
    int        cap_val;
    int        skew_val;
    int        guard;
    cmd_t      op;
    logic [QSEL_W-1:0] sel;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state, every status code, ticket extremes
    directed.push_back(checked_row(CMD_ADVANCE, 2'd0, 16'h0000,
                                   STATUS_EMPTY, 0, 16'h0000, 0, 0, 0, 0, 0, 0));
    directed.push_back(checked_row(CMD_ADVANCE, 2'd3, 16'hffff,
                                   STATUS_BAD_SEL, 0, 16'h0000, 0, 0, 0, 0, 0, 0));
    directed.push_back(checked_row(CMD_ADVANCE, 2'd1, 16'h0000,
                                   STATUS_EMPTY, 0, 16'h0000, 0, 0, 0, 0, 0, 0));
    directed.push_back(checked_row(CMD_ADVANCE, 2'd2, 16'h0000,
                                   STATUS_EMPTY, 0, 16'h0000, 0, 0, 0, 0, 0, 0));
    // enqueue ignores the selector, even the invalid one
    directed.push_back(checked_row(CMD_ENQUEUE, 2'd3, 16'hffff,
                                   STATUS_OK, 0, 16'h0000, 0, 0, 0, 1, 0, 0));
    directed.push_back(checked_row(CMD_ENQUEUE, 2'd0, 16'h0000,
                                   STATUS_OK, 0, 16'h0000, 0, 0, 0, 2, 0, 0));
    directed.push_back(checked_row(CMD_ENQUEUE, 2'd1, 16'ha5a5,
                                   STATUS_OK, 0, 16'h0000, 0, 0, 0, 3, 0, 0));
    // fourth ticket pushes queue 0 past the default skew: head moves to queue 1
    directed.push_back(checked_row(CMD_ENQUEUE, 2'd2, 16'h5a5a,
                                   STATUS_OK, 0, 16'h0000, 1, 0, 1, 3, 1, 0));
    directed.push_back(checked_row(CMD_ADVANCE, 2'd1, 16'h0000,
                                   STATUS_OK, 1, 16'hffff, 0, 0, 0, 3, 0, 0));
    directed.push_back(checked_row(CMD_ADVANCE, 2'd0, 16'h0000,
                                   STATUS_OK, 1, 16'h0000, 0, 0, 0, 2, 0, 0));
    directed.push_back(checked_row(CMD_ADVANCE, 2'd3, 16'h0000,
                                   STATUS_BAD_SEL, 0, 16'h0000, 0, 0, 0, 2, 0, 0));
    // limit lowered below the fill: tickets stay, every enqueue is full
    directed.push_back(cfg_row(CFG_QUEUE_LIMIT, 5'd0));
    directed.push_back(cfg_row(CFG_UNUSED_IDX, 5'd31));
    directed.push_back(checked_row(CMD_ENQUEUE, 2'd0, 16'h1234,
                                   STATUS_FULL, 0, 16'h0000, 0, 0, 0, 2, 0, 0));
    // zero skew with a full destination: head leaves queue 0 and is dropped
    directed.push_back(cfg_row(CFG_IMBALANCE_LIMIT, 5'd0));
    directed.push_back(item_row(CMD_ADVANCE, 2'd2, 16'h0000));
    directed.push_back(cfg_row(CFG_QUEUE_LIMIT, 5'd2));
    directed.push_back(cfg_row(CFG_IMBALANCE_LIMIT, 5'd16));
    directed.push_back(item_row(CMD_ENQUEUE, 2'd0, 16'h0001));
    directed.push_back(checked_row(CMD_ENQUEUE, 2'd0, 16'h0002,
                                   STATUS_FULL, 0, 16'h0000, 0, 0, 0, 2, 0, 0));
    // invalid selector still runs the rebalance pass
    directed.push_back(cfg_row(CFG_IMBALANCE_LIMIT, 5'd1));
    directed.push_back(item_row(CMD_ADVANCE, 2'd3, 16'h0000));
    directed.push_back(item_row(CMD_ADVANCE, 2'd1, 16'h0000));
    directed.push_back(item_row(CMD_ENQUEUE, 2'd1, 16'h8000));
    directed.push_back(item_row(CMD_ADVANCE, 2'd0, 16'h0000));
    directed.push_back(item_row(CMD_ADVANCE, 2'd1, 16'h0000));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_reg(directed[i].idx, directed[i].val[CFG_W-1:0]);
      end else begin
        idle_gap(35);
        send_row(directed[i]);
      end
    end

    // random phases: sender idles 35%, then 71%, then never; registers are
    // rewritten per phase, saturating and zero limits among them
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = (ph < 3) ? 35 : (ph < 6) ? 71 : 0;
      cap_val = (cap_plan[ph] < 0) ? $urandom_range(31) : cap_plan[ph];
      skew_val = (skew_plan[ph] < 0) ? $urandom_range(31) : skew_plan[ph];
      write_reg(CFG_QUEUE_LIMIT, cap_val[CFG_W-1:0]);
      write_reg(CFG_IMBALANCE_LIMIT, skew_val[CFG_W-1:0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < enq_plan[ph]) ? CMD_ENQUEUE : CMD_ADVANCE;
        // invalid selector kept rare so advances mostly reach a queue
        if (op == CMD_ENQUEUE || $urandom_range(9) == 0) sel = QSEL_W'($urandom_range(3));
        else sel = QSEL_W'($urandom_range(2));
        idle_gap(idle_pct);
        send_row(item_row(op, sel, TICKET_BITS'($urandom)));
      end
    end

    // drain, then wait out any stray strobe
    start <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (expected_results.size() != 0 && guard < 1000);
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== three_queue_balancer_top.f =====
hdl/tqb_pkg.sv
hdl/tqb_queue.sv
hdl/three_queue_balancer_top.sv
bench/testbench.sv
